/* src/bptf_pkg.sv */
`default_nettype none

package bptf_pkg;

  // Default memory sizes; both must be powers of two.
  localparam int unsigned PATTERN_BYTES_DFLT = 65536;
  localparam int unsigned PALETTE_BYTES_DFLT = 512;

  // Operation codes of an input word.
  localparam logic [1:0] OP_PAT_WR = 2'd0;
  localparam logic [1:0] OP_PAL_WR = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  // Depth codes.
  localparam logic [1:0] DEPTH_2BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;
  localparam logic [1:0] DEPTH_8BPP = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd7;

  // Register reset values.
  localparam logic [7:0]  TILE_WIDTH_RST   = 8'd8;
  localparam logic [7:0]  TILE_HEIGHT_RST  = 8'd8;
  localparam logic [1:0]  FLIP_MODE_RST    = 2'd0;
  localparam logic [1:0]  DEPTH_MODE_RST   = DEPTH_4BPP;
  localparam logic [15:0] BITMAP_BASE_RST  = 16'd0;
  localparam logic [8:0]  PALETTE_BASE_RST = 9'd0;
  localparam logic [9:0]  ORIGIN_X_RST     = 10'd0;
  localparam logic [9:0]  ORIGIN_Y_RST     = 10'd0;

  // Eight planes, held in eight pattern banks; plane pairs are 16 bytes apart.
  localparam int unsigned PLANES      = 8;
  localparam int unsigned PAIR_STRIDE = 16;
  // Widest pattern address sum: base + x and y tile offsets + row + plane offset.
  localparam int unsigned PAT_SUM_W   = 17;
  // Widest palette address sum: palette_base + 2 * index + 1.
  localparam int unsigned PAL_SUM_W   = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_byte;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [8:0]  screen_x;
    logic [7:0]  screen_y;
    logic [15:0] colour;
    logic        drawn;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  tile_width;
    logic [7:0]  tile_height;
    logic [1:0]  flip_mode;
    logic [1:0]  depth_mode;
    logic [15:0] bitmap_base;
    logic [8:0]  palette_base;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
  } cfg_t;

  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_byte;
    logic [7:0]  x;
    logic [7:0]  y;
  } pat_req_t;

  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_byte;
    logic [7:0]  index;
  } pal_req_t;

endpackage

`default_nettype wire

/* src/bptf_cfg.sv */
`default_nettype none

module bptf_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [bptf_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bptf_pkg::CFG_DATA_W-1:0]    wr_data,
  output bptf_pkg::cfg_t                     cfg
);
  import bptf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_TILE_WIDTH:   cfg_nxt.tile_width   = wr_data[7:0];
        CFG_TILE_HEIGHT:  cfg_nxt.tile_height  = wr_data[7:0];
        CFG_FLIP_MODE:    cfg_nxt.flip_mode    = wr_data[1:0];
        CFG_DEPTH_MODE:   cfg_nxt.depth_mode   = wr_data[1:0];
        CFG_BITMAP_BASE:  cfg_nxt.bitmap_base  = wr_data[15:0];
        CFG_PALETTE_BASE: cfg_nxt.palette_base = wr_data[8:0];
        CFG_ORIGIN_X:     cfg_nxt.origin_x     = wr_data[9:0];
        CFG_ORIGIN_Y:     cfg_nxt.origin_y     = wr_data[9:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_width   <= TILE_WIDTH_RST;
      cfg_r.tile_height  <= TILE_HEIGHT_RST;
      cfg_r.flip_mode    <= FLIP_MODE_RST;
      cfg_r.depth_mode   <= DEPTH_MODE_RST;
      cfg_r.bitmap_base  <= BITMAP_BASE_RST;
      cfg_r.palette_base <= PALETTE_BASE_RST;
      cfg_r.origin_x     <= ORIGIN_X_RST;
      cfg_r.origin_y     <= ORIGIN_Y_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/bptf_pat_mem.sv */
`default_nettype none

module bptf_pat_mem #(
  parameter int unsigned PATTERN_BYTES = bptf_pkg::PATTERN_BYTES_DFLT
) (
  input  logic                                           clk,
  input  bptf_pkg::pat_req_t                             req,
  input  bptf_pkg::cfg_t                                 cfg,
  output logic [bptf_pkg::PLANES-1:0][7:0]               plane_bytes
);
  import bptf_pkg::*;

  localparam int unsigned AW         = $clog2(PATTERN_BYTES);
  localparam int unsigned BANK_AW    = AW - 3;
  localparam int unsigned BANK_DEPTH = PATTERN_BYTES / PLANES;

  logic [PAT_SUM_W-1:0] x_off;
  logic [PAT_SUM_W-1:0] y_off;
  logic [PAT_SUM_W-1:0] base;
  logic [AW-1:0]        rd_full [PLANES];
  logic [2:0]           rd_bank [PLANES];
  logic [BANK_AW-1:0]   bank_raddr [PLANES];
  logic [AW-1:0]        wr_full;
  logic [2:0]           wr_bank;
  logic [BANK_AW-1:0]   wr_entry;
  logic [7:0]           bank_q [PLANES];
  logic [5:0]           base_lo_r;
  logic [5:0]           lo_addr;

  // Tile row base in the pattern memory.
  always_comb begin
    unique case (cfg.depth_mode)
      DEPTH_2BPP: begin
        x_off = PAT_SUM_W'({req.x[7:3], 4'b0});
        y_off = PAT_SUM_W'({req.y[7:3], 8'b0});
      end
      DEPTH_4BPP: begin
        x_off = PAT_SUM_W'({req.x[7:3], 5'b0});
        y_off = PAT_SUM_W'({req.y[7:3], 9'b0});
      end
      default: begin
        x_off = PAT_SUM_W'({req.x[7:3], 6'b0});
        y_off = PAT_SUM_W'({req.y[7:3], 10'b0});
      end
    endcase
    base = PAT_SUM_W'(cfg.bitmap_base) + x_off + y_off
         + PAT_SUM_W'({req.y[2:0], 1'b0});
  end

  // The eight plane bytes sit at base + 16p + q. Address bit 0 and bits 5:4 differ
  // between all eight, so each lands in its own bank and all are read at once.
  always_comb begin
    for (int k = 0; k < PLANES; k++) begin
      rd_full[k] = AW'(base + PAT_SUM_W'((k / 2) * PAIR_STRIDE + (k % 2)));
      rd_bank[k] = {rd_full[k][0], rd_full[k][5:4]};
    end
    for (int j = 0; j < PLANES; j++) begin
      bank_raddr[j] = '0;
      for (int k = 0; k < PLANES; k++) begin
        if (rd_bank[k] == 3'(j)) begin
          bank_raddr[j] = {rd_full[k][AW-1:6], rd_full[k][3:1]};
        end
      end
    end
  end

  assign wr_full  = AW'(req.wr_addr);
  assign wr_bank  = {wr_full[0], wr_full[5:4]};
  assign wr_entry = {wr_full[AW-1:6], wr_full[3:1]};

  for (genvar j = 0; j < PLANES; j++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (req.wr_en && (wr_bank == 3'(j))) begin
        mem[wr_entry] <= req.wr_byte;
      end
      if (req.rd_en) begin
        bank_q[j] <= mem[bank_raddr[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      base_lo_r <= base[5:0];
    end
  end

  // Put the bank outputs back in plane order.
  always_comb begin
    for (int k = 0; k < PLANES; k++) begin
      lo_addr        = base_lo_r + 6'((k / 2) * PAIR_STRIDE + (k % 2));
      plane_bytes[k] = bank_q[{lo_addr[0], lo_addr[5:4]}];
    end
  end

endmodule

`default_nettype wire

/* src/bptf_pal_mem.sv */
`default_nettype none

module bptf_pal_mem #(
  parameter int unsigned PALETTE_BYTES = bptf_pkg::PALETTE_BYTES_DFLT
) (
  input  logic                clk,
  input  bptf_pkg::pal_req_t  req,
  input  bptf_pkg::cfg_t      cfg,
  output logic [15:0]         colour
);
  import bptf_pkg::*;

  localparam int unsigned PAW        = $clog2(PALETTE_BYTES);
  localparam int unsigned BANK_AW    = PAW - 1;
  localparam int unsigned BANK_DEPTH = PALETTE_BYTES / 2;

  logic [PAL_SUM_W-1:0] pa_lo_sum;
  logic [PAW-1:0]       pa_lo;
  logic [PAW-1:0]       pa_hi;
  logic [PAW-1:0]       wr_full;
  logic [BANK_AW-1:0]   bank_raddr [2];
  logic [7:0]           bank_q [2];
  logic                 lo_par_r;

  // Low and high bytes of an entry always differ in bit 0, so they come from
  // the even and the odd bank in the same cycle.
  assign pa_lo_sum = PAL_SUM_W'(cfg.palette_base) + PAL_SUM_W'({req.index, 1'b0});
  assign pa_lo     = PAW'(pa_lo_sum);
  assign pa_hi     = PAW'(pa_lo_sum + PAL_SUM_W'(1));
  assign wr_full   = PAW'(req.wr_addr);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      bank_raddr[c] = (pa_lo[0] == 1'(c)) ? pa_lo[PAW-1:1] : pa_hi[PAW-1:1];
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (req.wr_en && (wr_full[0] == 1'(c))) begin
        mem[wr_full[PAW-1:1]] <= req.wr_byte;
      end
      if (req.rd_en) begin
        bank_q[c] <= mem[bank_raddr[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      lo_par_r <= pa_lo[0];
    end
  end

  assign colour = {bank_q[~lo_par_r], bank_q[lo_par_r]};

endmodule

`default_nettype wire

/* src/bitplane_tile_pixel_fetch_core.sv */
`default_nettype none

// Channel   Ports                          Handshake
// input     start, busy, in_word           taken at an edge with start high, busy low
// result    out_valid, out_word            one-cycle strobe, receiver cannot stall
// config    cfg_valid, cfg_ready,          written at an edge with valid and ready high
//           cfg_index, cfg_data
//
// One word is taken in each cycle in which start is high and busy is low. A fetch
// passes through registered steps in order: the flip, the eight-bank pattern read,
// the two-bank palette read and the output register.
// Reset is synchronous and active low; busy is high in the first cycle after it.
// Memory contents are not cleared by reset. Nothing in the block ever stalls.

module bitplane_tile_pixel_fetch_core #(
  parameter int unsigned PATTERN_BYTES = bptf_pkg::PATTERN_BYTES_DFLT,
  parameter int unsigned PALETTE_BYTES = bptf_pkg::PALETTE_BYTES_DFLT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bptf_pkg::in_word_t               in_word,
  output logic                             out_valid,
  output bptf_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bptf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bptf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bptf_pkg::*;

  cfg_t       cfg;
  logic       busy_r;
  logic       in_acc;
  logic [7:0] flip_x;
  logic [7:0] flip_y;
  logic       in_area;

  logic       s1_vld_r;
  logic [1:0] s1_op_r;
  logic [15:0] s1_addr_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_x_r;
  logic [7:0] s1_y_r;
  logic       s1_inside_r;
  logic [8:0] s1_sx_r;
  logic [7:0] s1_sy_r;

  logic       s2_vld_r;
  logic [1:0] s2_op_r;
  logic [15:0] s2_addr_r;
  logic [7:0] s2_byte_r;
  logic [2:0] s2_xb_r;
  logic       s2_inside_r;
  logic [8:0] s2_sx_r;
  logic [7:0] s2_sy_r;

  logic       s3_vld_r;
  logic       s3_drawn_r;
  logic [8:0] s3_sx_r;
  logic [7:0] s3_sy_r;

  logic       out_valid_r;
  out_word_t  out_word_r;

  pat_req_t                pat_req;
  pal_req_t                pal_req;
  logic [PLANES-1:0][7:0]  plane_bytes;
  logic [PLANES-1:0]       plane_mask;
  logic [7:0]              index;
  logic [15:0]             pal_colour;

  bptf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign in_acc    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Flip inside the tile area; out-of-area pixels are never drawn.
  assign flip_x = cfg.flip_mode[0] ? (cfg.tile_width - 8'd1 - in_word.pixel_col)
                                   : in_word.pixel_col;
  assign flip_y = cfg.flip_mode[1] ? (cfg.tile_height - 8'd1 - in_word.pixel_row)
                                   : in_word.pixel_row;
  assign in_area = (in_word.pixel_col < cfg.tile_width)
                && (in_word.pixel_row < cfg.tile_height)
                && (cfg.depth_mode <= DEPTH_8BPP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= in_acc;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r && (s2_op_r == OP_FETCH);
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_word.operation;
      s1_addr_r   <= in_word.address;
      s1_byte_r   <= in_word.write_byte;
      s1_x_r      <= flip_x;
      s1_y_r      <= flip_y;
      s1_inside_r <= in_area;
      s1_sx_r     <= cfg.origin_x[8:0] + 9'(in_word.pixel_col);
      s1_sy_r     <= cfg.origin_y[7:0] + in_word.pixel_row;
    end
    s2_op_r     <= s1_op_r;
    s2_addr_r   <= s1_addr_r;
    s2_byte_r   <= s1_byte_r;
    s2_xb_r     <= s1_x_r[2:0];
    s2_inside_r <= s1_inside_r;
    s2_sx_r     <= s1_sx_r;
    s2_sy_r     <= s1_sy_r;
    s3_drawn_r  <= s2_inside_r && (index != 8'd0);
    s3_sx_r     <= s2_sx_r;
    s3_sy_r     <= s2_sy_r;
    out_word_r.screen_x <= s3_sx_r;
    out_word_r.screen_y <= s3_sy_r;
    out_word_r.colour   <= s3_drawn_r ? pal_colour : 16'd0;
    out_word_r.drawn    <= s3_drawn_r;
  end

  // Every item touches each memory at one fixed stage, so memory accesses keep
  // the order of the input words and no forwarding is needed.
  always_comb begin
    pat_req.wr_en   = s1_vld_r && (s1_op_r == OP_PAT_WR);
    pat_req.rd_en   = s1_vld_r && (s1_op_r == OP_FETCH);
    pat_req.wr_addr = s1_addr_r;
    pat_req.wr_byte = s1_byte_r;
    pat_req.x       = s1_x_r;
    pat_req.y       = s1_y_r;
  end

  bptf_pat_mem #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_pat_mem (
    .clk         (clk),
    .req         (pat_req),
    .cfg         (cfg),
    .plane_bytes (plane_bytes)
  );

  always_comb begin
    unique case (cfg.depth_mode)
      DEPTH_2BPP: plane_mask = 8'h03;
      DEPTH_4BPP: plane_mask = 8'h0F;
      DEPTH_8BPP: plane_mask = 8'hFF;
      default:    plane_mask = 8'h00;
    endcase
    for (int k = 0; k < PLANES; k++) begin
      index[k] = plane_mask[k] & plane_bytes[k][3'd7 - s2_xb_r];
    end
  end

  always_comb begin
    pal_req.wr_en   = s2_vld_r && (s2_op_r == OP_PAL_WR);
    pal_req.rd_en   = s2_vld_r && (s2_op_r == OP_FETCH);
    pal_req.wr_addr = s2_addr_r;
    pal_req.wr_byte = s2_byte_r;
    pal_req.index   = index;
  end

  bptf_pal_mem #(
    .PALETTE_BYTES (PALETTE_BYTES)
  ) u_pal_mem (
    .clk    (clk),
    .req    (pal_req),
    .cfg    (cfg),
    .colour (pal_colour)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_out_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_word.operation == OP_FETCH), 4))
    else $error("result word without a fetch four cycles earlier");

  a_blank_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.drawn) |-> (out_word.colour == 16'd0))
    else $error("undrawn pixel carries a colour");

  a_outside_not_drawn: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && (s2_op_r == OP_FETCH) && !s2_inside_r) |=> !s3_drawn_r)
    else $error("pixel outside the tile area marked drawn");
`endif

endmodule

`default_nettype wire

/* verif/bitplane_tile_pixel_fetch_core_tb.sv */
`default_nettype none

module bitplane_tile_pixel_fetch_core_tb;
  import bptf_pkg::*;

  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_WORDS   = 250;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  DEPTH_UNUSED  = 2'd3;

  // Predicts the pixel stream from its own copy of both memories and the registers.
  class pixel_fetch_scoreboard;
    logic [7:0] pat_mem [PATTERN_BYTES_DFLT];
    bit         pat_written [PATTERN_BYTES_DFLT];
    logic [7:0] pal_mem [PALETTE_BYTES_DFLT];
    bit         pal_written [PALETTE_BYTES_DFLT];
    cfg_t       regs;
    out_word_t  expected_pixels [$];
    int unsigned errors;

    function new();
      regs.tile_width   = TILE_WIDTH_RST;
      regs.tile_height  = TILE_HEIGHT_RST;
      regs.flip_mode    = FLIP_MODE_RST;
      regs.depth_mode   = DEPTH_MODE_RST;
      regs.bitmap_base  = BITMAP_BASE_RST;
      regs.palette_base = PALETTE_BASE_RST;
      regs.origin_x     = ORIGIN_X_RST;
      regs.origin_y     = ORIGIN_Y_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TILE_WIDTH:   regs.tile_width   = data[7:0];
        CFG_TILE_HEIGHT:  regs.tile_height  = data[7:0];
        CFG_FLIP_MODE:    regs.flip_mode    = data[1:0];
        CFG_DEPTH_MODE:   regs.depth_mode   = data[1:0];
        CFG_BITMAP_BASE:  regs.bitmap_base  = data[15:0];
        CFG_PALETTE_BASE: regs.palette_base = data[8:0];
        CFG_ORIGIN_X:     regs.origin_x     = data[9:0];
        CFG_ORIGIN_Y:     regs.origin_y     = data[9:0];
        default: ;
      endcase
    endfunction

    // True when a fetch at this position lies in the tile area with a valid depth mode.
    function bit covers(logic [7:0] col, logic [7:0] row);
      return col < regs.tile_width && row < regs.tile_height && regs.depth_mode <= DEPTH_8BPP;
    endfunction

    function int unsigned plane_count();
      return 2 << regs.depth_mode;
    endfunction

    function logic [7:0] flip_col(logic [7:0] col);
      return regs.flip_mode[0] ? regs.tile_width - 8'd1 - col : col;
    endfunction

    function logic [7:0] flip_row(logic [7:0] row);
      return regs.flip_mode[1] ? regs.tile_height - 8'd1 - row : row;
    endfunction

    // Byte address of one plane for a flipped position; pairs of planes are interleaved.
    function logic [15:0] plane_addr(logic [7:0] x, logic [7:0] y, int unsigned plane);
      int unsigned xi, yi, shift, sum;
      xi = x;
      yi = y;
      shift = 4 + regs.depth_mode;
      sum = regs.bitmap_base + ((xi >> 3) << shift) + ((yi >> 3) << (shift + 4))
          + ((yi & 7) << 1) + PAIR_STRIDE * (plane / 2) + plane % 2;
      return 16'(sum);
    endfunction

    function logic [7:0] pixel_index(logic [7:0] col, logic [7:0] row);
      logic [7:0] x, y, idx;
      int unsigned p;
      x = flip_col(col);
      y = flip_row(row);
      idx = '0;
      for (p = 0; p < plane_count(); p++) begin
        idx[p] = pat_mem[plane_addr(x, y, p)][7 - x[2:0]];
      end
      return idx;
    endfunction

    function logic [8:0] pal_addr(logic [7:0] idx, bit high);
      int unsigned sum;
      sum = regs.palette_base + 2 * int'(idx) + high;
      return 9'(sum % PALETTE_BYTES_DFLT);
    endfunction

    function void note_word(in_word_t w);
      out_word_t  want;
      logic [7:0] idx;
      case (w.operation)
        OP_PAT_WR: begin
          pat_mem[w.address] = w.write_byte;
          pat_written[w.address] = 1'b1;
        end
        OP_PAL_WR: begin
          pal_mem[w.address % PALETTE_BYTES_DFLT] = w.write_byte;
          pal_written[w.address % PALETTE_BYTES_DFLT] = 1'b1;
        end
        OP_FETCH: begin
          want.screen_x = 9'(regs.origin_x + w.pixel_col);
          want.screen_y = 8'(regs.origin_y + w.pixel_row);
          want.colour = '0;
          want.drawn = 1'b0;
          if (covers(w.pixel_col, w.pixel_row)) begin
            idx = pixel_index(w.pixel_col, w.pixel_row);
            if (idx != 8'd0) begin
              want.colour = {pal_mem[pal_addr(idx, 1'b1)], pal_mem[pal_addr(idx, 1'b0)]};
              want.drawn = 1'b1;
            end
          end
          expected_pixels.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel with none expected: expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.screen_x !== want.screen_x) begin
        $display("%0t: screen_x expected %0d actual %0d", $time, want.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== want.screen_y) begin
        $display("%0t: screen_y expected %0d actual %0d", $time, want.screen_y, got.screen_y);
        errors++;
      end
      if (got.colour !== want.colour) begin
        $display("%0t: colour expected %h actual %h", $time, want.colour, got.colour);
        errors++;
      end
      if (got.drawn !== want.drawn) begin
        $display("%0t: drawn expected %b actual %b", $time, want.drawn, got.drawn);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_word_t              in_word;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_fetch_scoreboard sb;
  int unsigned idle_pct;
  int unsigned words_sent;
  int unsigned cycle_count = 0;

  bitplane_tile_pixel_fetch_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("bitplane_tile_pixel_fetch_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_pixel(out_word);
    end
  end

  // Start stays high from one word to the next; it drops only for an idle gap or in settle.
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    if (w.operation != OP_UNUSED) begin
      words_sent++;
    end
  endtask

  task automatic send_op(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                         logic [7:0] col, logic [7:0] row);
    in_word_t w;
    w.operation = op;
    w.address = addr;
    w.write_byte = data;
    w.pixel_col = col;
    w.pixel_row = row;
    send_word(w);
  endtask

  // Where the pixel is covered, writes each unwritten byte it depends on, then fetches.
  task automatic fetch_pixel(logic [7:0] col, logic [7:0] row);
    logic [15:0] pa;
    logic [8:0]  ca;
    logic [7:0]  idx;
    int unsigned p;
    if (sb.covers(col, row)) begin
      for (p = 0; p < sb.plane_count(); p++) begin
        pa = sb.plane_addr(sb.flip_col(col), sb.flip_row(row), p);
        if (!sb.pat_written[pa]) begin
          send_op(OP_PAT_WR, pa, $urandom, $urandom, $urandom);
        end
      end
      idx = sb.pixel_index(col, row);
      if (idx != 8'd0) begin
        for (p = 0; p < 2; p++) begin
          ca = sb.pal_addr(idx, p[0]);
          if (!sb.pal_written[ca]) begin
            send_op(OP_PAL_WR, {7'($urandom_range(127)), ca}, $urandom, $urandom, $urandom);
          end
        end
      end
    end
    send_op(OP_FETCH, $urandom, $urandom, col, row);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_phase(int unsigned ph);
    logic [15:0] w, h, flip, depth, bb, pb, ox, oy;
    w = ($urandom_range(1) != 0) ? $urandom_range(16, 1) : $urandom_range(255, 1);
    h = ($urandom_range(1) != 0) ? $urandom_range(16, 1) : $urandom_range(255, 1);
    flip = $urandom_range(3);
    depth = ($urandom_range(9) == 0) ? DEPTH_UNUSED : $urandom_range(2);
    bb = $urandom_range(16'hffff);
    pb = $urandom_range(511);
    ox = $urandom_range(1023);
    oy = $urandom_range(1023);
    case (ph)
      0: begin
        w = 255; h = 255; flip = 3; depth = DEPTH_8BPP;
        bb = 16'hffff; pb = 511; ox = 1023; oy = 1023;
      end
      1: begin
        w = 1; h = 1; flip = 0; depth = DEPTH_2BPP;
        bb = 0; pb = 0; ox = 0; oy = 0;
      end
      2: begin
        w = 0; h = 255;
      end
      3: depth = DEPTH_UNUSED;
      default: ;
    endcase
    cfg_write(CFG_TILE_WIDTH, w);
    cfg_write(CFG_TILE_HEIGHT, h);
    cfg_write(CFG_FLIP_MODE, flip);
    cfg_write(CFG_DEPTH_MODE, depth);
    cfg_write(CFG_BITMAP_BASE, bb);
    cfg_write(CFG_PALETTE_BASE, pb);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned ph, phase_start, pick;
    logic [7:0] col, row;
    sb = new();
    idle_pct = 0;
    words_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: 4 bpp, 8x8 tile at the origin. Row 0 of tile 0 uses
    // bytes 0, 1, 16 and 17, so column 0 has index 1 and column 7 index 9.
    send_op(OP_PAT_WR, 16'd0, 8'h81, 8'd0, 8'd0);
    send_op(OP_PAT_WR, 16'd1, 8'h00, 8'd0, 8'd0);
    send_op(OP_PAT_WR, 16'd16, 8'h00, 8'd0, 8'd0);
    send_op(OP_PAT_WR, 16'd17, 8'h01, 8'd0, 8'd0);
    send_op(OP_PAL_WR, 16'd2, 8'hff, 8'd0, 8'd0);
    send_op(OP_PAL_WR, 16'd3, 8'hff, 8'd0, 8'd0);
    send_op(OP_PAL_WR, 16'd18, 8'h34, 8'd0, 8'd0);
    send_op(OP_PAL_WR, 16'd19, 8'h12, 8'd0, 8'd0);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd0, 8'd0);
    send_op(OP_FETCH, 16'hffff, 8'hff, 8'd7, 8'd0);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd3, 8'd0);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd8, 8'd0);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd0, 8'd8);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd255, 8'd255);
    send_op(OP_UNUSED, 16'hffff, 8'hff, 8'd255, 8'd255);
    send_op(OP_PAT_WR, 16'hffff, 8'hff, 8'd255, 8'd255);
    send_op(OP_PAL_WR, 16'hffff, 8'h00, 8'd255, 8'd255);
    // Clearing a byte right before the fetch that reads it turns the pixel transparent.
    send_op(OP_PAT_WR, 16'd0, 8'h00, 8'd0, 8'd0);
    send_op(OP_FETCH, 16'd0, 8'd0, 8'd0, 8'd0);
    fetch_pixel(8'd7, 8'd0);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph < 2) ? 8 : ((ph < 5) ? 48 : 0);
      program_phase(ph);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          if (sb.regs.tile_width != 0 && sb.regs.tile_height != 0 &&
              $urandom_range(3) != 0) begin
            col = $urandom_range(sb.regs.tile_width - 1);
            row = $urandom_range(sb.regs.tile_height - 1);
          end else begin
            col = $urandom;
            row = $urandom;
          end
          fetch_pixel(col, row);
        end else if (pick < 85) begin
          send_op(OP_PAT_WR, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 93) begin
          send_op(OP_PAL_WR, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 97) begin
          send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 99) begin
          fetch_pixel($urandom, $urandom);
        end else begin
          settle();
        end
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("bitplane_tile_pixel_fetch_core test passed");
    end else begin
      $display("bitplane_tile_pixel_fetch_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
